### design/command_frame_receiver_top_defines.svh
// Assertion macros shared by the command frame receiver modules.
// Included by cfr_framer and command_frame_receiver_top; no other dependencies.
`ifndef COMMAND_FRAME_RECEIVER_TOP_DEFINES_SVH
`define COMMAND_FRAME_RECEIVER_TOP_DEFINES_SVH

// Check a property at every rising edge outside of reset.
`define CFR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every rising edge, reset included.
`define CFR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/cfr_pkg.sv
// Shared types, constants and the CRC-8 helper of the command frame receiver.
// No dependencies; used by every module of the block.
`default_nettype none

package cfr_pkg;

  localparam int unsigned ELAPSED_WIDTH = 16;
  localparam int unsigned TIMEOUT_WIDTH = 16;
  localparam int unsigned CMP_WIDTH =
    (ELAPSED_WIDTH > TIMEOUT_WIDTH) ? ELAPSED_WIDTH : TIMEOUT_WIDTH;

  localparam logic [ELAPSED_WIDTH-1:0] ELAPSED_MAX = '1;

  localparam logic [7:0] FRAME_START = 8'hAA;
  localparam logic [7:0] FRAME_END   = 8'h55;
  localparam logic [7:0] CHECK_POLY  = 8'h07;

  // Event codes carried in the mode field; the fourth code is a no-op.
  localparam logic [1:0] MODE_BYTE     = 2'd0;
  localparam logic [1:0] MODE_LINE_ERR = 2'd1;
  localparam logic [1:0] MODE_TICK     = 2'd2;

  // Bytes of the frame taken in so far.
  typedef enum logic [2:0] {
    FP_HUNT,
    FP_SEQ,
    FP_BTN,
    FP_CHK,
    FP_END
  } frame_pos_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] buttons;
    logic [7:0] sequence_res;
    logic       has_command;
    logic       timed_out;
    logic       frame_accepted;
  } res_t;

  // One byte of CRC-8, MSB first, no reflection.
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc_in, input logic [7:0] din);
    logic [7:0] c;
    c = crc_in ^ din;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CHECK_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### design/cfr_in_if.sv
// Input request channel of the command frame receiver: valid, ready, event payload.
// Standalone; no package dependencies.
`default_nettype none

interface cfr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

`default_nettype wire

### design/cfr_res_if.sv
// Result channel of the command frame receiver: valid, ready, status payload.
// Standalone; no package dependencies.
`default_nettype none

interface cfr_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] buttons;
  logic [7:0] sequence_res;
  logic       has_command;
  logic       timed_out;
  logic       frame_accepted;

  modport source (output valid, output buttons, output sequence_res, output has_command,
                  output timed_out, output frame_accepted, input ready);
  modport sink   (input valid, input buttons, input sequence_res, input has_command,
                  input timed_out, input frame_accepted, output ready);
endinterface

`default_nettype wire

### design/cfr_cfg_if.sv
// Configuration write channel of the command frame receiver: the timeout register.
// Standalone; no package dependencies.
`default_nettype none

interface cfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] wait_limit;

  modport source (output valid, output wait_limit, input ready);
  modport sink   (input valid, input wait_limit, output ready);
endinterface

`default_nettype wire

### design/cfr_framer.sv
// Frame state machine, CRC check, latched command and elapsed-time counter.
// Depends on cfr_pkg and command_frame_receiver_top_defines.svh.
`default_nettype none
`include "command_frame_receiver_top_defines.svh"

module cfr_framer (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         step_i,
  input  wire cfr_pkg::item_t               item_i,
  input  wire logic [cfr_pkg::TIMEOUT_WIDTH-1:0] wait_limit_i,
  output cfr_pkg::res_t                     res_o
);

  cfr_pkg::frame_pos_e state_q, state_d;
  logic [7:0] pend_seq_q, pend_seq_d;
  logic [7:0] pend_btn_q, pend_btn_d;
  logic [7:0] pend_chk_q, pend_chk_d;
  logic [7:0] held_seq_q, held_seq_d;
  logic [7:0] held_btn_q, held_btn_d;
  logic       cmd_seen_q, cmd_seen_d;
  logic [cfr_pkg::ELAPSED_WIDTH-1:0] elapsed_q, elapsed_d;
  logic       crc_ok;
  logic       accepted;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= cfr_pkg::FP_HUNT;
      held_seq_q <= '0;
      held_btn_q <= '0;
      cmd_seen_q <= 1'b0;
      elapsed_q  <= '0;
    end else begin
      state_q    <= state_d;
      held_seq_q <= held_seq_d;
      held_btn_q <= held_btn_d;
      cmd_seen_q <= cmd_seen_d;
      elapsed_q  <= elapsed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_seq_q <= pend_seq_d;
    pend_btn_q <= pend_btn_d;
    pend_chk_q <= pend_chk_d;
  end

  assign crc_ok = cfr_pkg::crc8_feed(cfr_pkg::crc8_feed(8'h00, pend_seq_q), pend_btn_q)
                  == pend_chk_q;

  always_comb begin
    state_d    = state_q;
    pend_seq_d = pend_seq_q;
    pend_btn_d = pend_btn_q;
    pend_chk_d = pend_chk_q;
    held_seq_d = held_seq_q;
    held_btn_d = held_btn_q;
    cmd_seen_d = cmd_seen_q;
    elapsed_d  = elapsed_q;
    accepted   = 1'b0;

    if (step_i) begin
      unique case (item_i.mode)
        cfr_pkg::MODE_BYTE: begin
          unique case (state_q)
            cfr_pkg::FP_HUNT: begin
              if (item_i.data_byte == cfr_pkg::FRAME_START) state_d = cfr_pkg::FP_SEQ;
            end
            cfr_pkg::FP_SEQ: begin
              pend_seq_d = item_i.data_byte;
              state_d    = cfr_pkg::FP_BTN;
            end
            cfr_pkg::FP_BTN: begin
              pend_btn_d = item_i.data_byte;
              state_d    = cfr_pkg::FP_CHK;
            end
            cfr_pkg::FP_CHK: begin
              pend_chk_d = item_i.data_byte;
              state_d    = cfr_pkg::FP_END;
            end
            cfr_pkg::FP_END: begin
              if (item_i.data_byte == cfr_pkg::FRAME_END && crc_ok) begin
                held_seq_d = pend_seq_q;
                held_btn_d = pend_btn_q;
                cmd_seen_d = 1'b1;
                elapsed_d  = '0;
                accepted   = 1'b1;
              end
              // closing byte may open the next frame
              state_d = (item_i.data_byte == cfr_pkg::FRAME_START) ? cfr_pkg::FP_SEQ
                                                                     : cfr_pkg::FP_HUNT;
            end
            default: state_d = cfr_pkg::FP_HUNT;
          endcase
        end
        cfr_pkg::MODE_LINE_ERR: state_d = cfr_pkg::FP_HUNT;
        cfr_pkg::MODE_TICK: begin
          // saturate instead of wrapping
          if (elapsed_q != cfr_pkg::ELAPSED_MAX) elapsed_d = elapsed_q + 1'b1;
        end
        default: ;
      endcase
    end

    res_o.buttons        = held_btn_d;
    res_o.sequence_res   = held_seq_d;
    res_o.has_command    = cmd_seen_d;
    res_o.timed_out      = !cmd_seen_d ||
                           (cfr_pkg::CMP_WIDTH'(elapsed_d) >= cfr_pkg::CMP_WIDTH'(wait_limit_i));
    res_o.frame_accepted = accepted;
  end

  `CFR_ASSERT(a_accept_at_end, clk_i, rst_ni,
              res_o.frame_accepted |-> step_i && state_q == cfr_pkg::FP_END,
              "frame accepted outside end position")
  `CFR_ASSERT(a_accept_latches, clk_i, rst_ni,
              res_o.frame_accepted |=> cmd_seen_q && elapsed_q == '0,
              "accepted frame did not latch command")
  `CFR_ASSERT(a_line_err_hunt, clk_i, rst_ni,
              step_i && item_i.mode == cfr_pkg::MODE_LINE_ERR |=> state_q == cfr_pkg::FP_HUNT,
              "line error did not reset framing")
  `CFR_ASSERT(a_idle_holds, clk_i, rst_ni,
              !step_i |=> $stable(elapsed_q) && $stable(cmd_seen_q) && $stable(state_q),
              "state changed without a request")

endmodule

`default_nettype wire

### design/command_frame_receiver_top.sv
// Channel   | Dir | Payload                                                    | Role
// in_ch     | in  | mode, data_byte                                            | event request
// out_ch    | out | buttons, sequence_res, has_command, timed_out, frame_accepted | status result
// cfg_ch    | in  | wait_limit                                                 | timeout register write
//
// One request per cycle sustained while out_ch.ready stays high; a request passes the input register,
// then the framer logic into the result register.
// Every request yields exactly one result; the framer state advances as a request moves
// from the input register into the result register.
// A stalled result holds the pipe; the input register still takes a request when empty.
// rst_ni clears framing, latched command, elapsed time and the timeout limit to zero.
// Depends on cfr_pkg, the cfr_*_if interfaces, cfr_framer and the defines header.
`default_nettype none
`include "command_frame_receiver_top_defines.svh"

module command_frame_receiver_top (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cfr_in_if.sink     in_ch,
  cfr_res_if.source  out_ch,
  cfr_cfg_if.sink    cfg_ch
);

  logic           s1_valid_q, s1_valid_d;
  cfr_pkg::item_t s1_item_q;
  logic           out_valid_q, out_valid_d;
  cfr_pkg::res_t  out_res_q;
  cfr_pkg::res_t  framer_res;
  logic [cfr_pkg::TIMEOUT_WIDTH-1:0] timeout_q;
  logic           out_free;
  logic           s1_adv;
  logic           in_fire;

  assign out_free     = !out_valid_q || out_ch.ready;
  assign s1_adv       = s1_valid_q && out_free;
  assign in_ch.ready  = !s1_valid_q || out_free;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      timeout_q   <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_ch.valid) timeout_q <= cfg_ch.wait_limit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q.mode      <= in_ch.mode;
      s1_item_q.data_byte <= in_ch.data_byte;
    end
    if (s1_adv) out_res_q <= framer_res;
  end

  cfr_framer u_framer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (s1_adv),
    .item_i       (s1_item_q),
    .wait_limit_i (timeout_q),
    .res_o        (framer_res)
  );

  assign out_ch.valid          = out_valid_q;
  assign out_ch.buttons        = out_res_q.buttons;
  assign out_ch.sequence_res   = out_res_q.sequence_res;
  assign out_ch.has_command    = out_res_q.has_command;
  assign out_ch.timed_out      = out_res_q.timed_out;
  assign out_ch.frame_accepted = out_res_q.frame_accepted;

  `CFR_ASSERT_ALWAYS(a_reset_empty, clk_i,
                     !rst_ni |=> !s1_valid_q && !out_valid_q,
                     "pipe not empty after a reset edge")
  `CFR_ASSERT(a_adv_fills_out, clk_i, rst_ni,
              s1_adv |=> out_valid_q,
              "advanced request produced no result")
  `CFR_ASSERT(a_empty_ready, clk_i, rst_ni,
              !s1_valid_q |-> in_ch.ready,
              "empty input register refused a request")
  `CFR_ASSERT(a_stall_holds_s1, clk_i, rst_ni,
              s1_valid_q && !out_free |=> s1_valid_q && $stable(s1_item_q),
              "stalled request lost")

endmodule

`default_nettype wire
